// File: src/ustc_pkg.sv
// Shared constants and the month offset table for the seconds-to-calendar pipeline.
package ustc_pkg;

  // Number of register stages from the input port to the output registers.
  localparam int unsigned STAGES = 8;

  // Julian day number of 1970-01-01, and the offset of the integer date method.
  localparam int unsigned EPOCH_JDN  = 2440588;
  localparam int unsigned JDN_OFFSET = 32044;
  localparam int unsigned DAY_BASE   = EPOCH_JDN + JDN_OFFSET;
  localparam int unsigned DAYS_WEEK  = 7;
  localparam int unsigned WEEK_BIAS  = EPOCH_JDN % DAYS_WEEK;

  // 86400 seconds per day is 675 shifted left by 7.
  localparam int unsigned DAY_LO_BITS = 7;
  localparam int unsigned DAY_DIV     = 675;

  localparam int unsigned DAYS_400Y  = 146097;
  localparam int unsigned DAYS_4Y    = 1461;
  localparam int unsigned MQ_DIV     = 153;
  localparam int unsigned SECS_HOUR  = 3600;
  localparam int unsigned SECS_MIN   = 60;
  localparam int unsigned CENT_YEARS = 100;
  localparam int unsigned YEAR_BIAS  = 4800;
  localparam int unsigned MONTH_WRAP = 10;
  localparam int unsigned MONTH_BACK = 9;
  localparam int unsigned MONTH_FWD  = 3;

  // Reciprocal shifts: numerator width plus the divisor's bit length, which
  // makes the rounded-up reciprocal exact over the whole numerator range.
  localparam int unsigned DAY_SHIFT  = 35;
  localparam int unsigned CENT_SHIFT = 42;
  localparam int unsigned QUAD_SHIFT = 29;
  localparam int unsigned MQ_SHIFT   = 19;
  localparam int unsigned HOUR_SHIFT = 29;
  localparam int unsigned MIN_SHIFT  = 18;
  localparam int unsigned WEEK_SHIFT = 19;

  localparam longint unsigned DAY_RCP  =
    ((longint'(1) << DAY_SHIFT) + DAY_DIV - 1) / DAY_DIV;
  localparam longint unsigned CENT_RCP =
    ((longint'(1) << CENT_SHIFT) + DAYS_400Y - 1) / DAYS_400Y;
  localparam longint unsigned QUAD_RCP =
    ((longint'(1) << QUAD_SHIFT) + DAYS_4Y - 1) / DAYS_4Y;
  localparam longint unsigned MQ_RCP   =
    ((longint'(1) << MQ_SHIFT) + MQ_DIV - 1) / MQ_DIV;
  localparam longint unsigned HOUR_RCP =
    ((longint'(1) << HOUR_SHIFT) + SECS_HOUR - 1) / SECS_HOUR;
  localparam longint unsigned MIN_RCP  =
    ((longint'(1) << MIN_SHIFT) + SECS_MIN - 1) / SECS_MIN;
  localparam longint unsigned WEEK_RCP =
    ((longint'(1) << WEEK_SHIFT) + DAYS_WEEK - 1) / DAYS_WEEK;

  // Day of the March-based year on which each month starts: (153*m+2)/5.
  function automatic logic [8:0] month_start(input logic [3:0] mq);
    logic [8:0] res;
    unique case (mq)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// File: src/unix_seconds_to_calendar_top.sv
// Pipelined conversion of Unix seconds to Gregorian date, time of day and weekday.
//
//   Channel  Direction  Handshake                    Payload
//   in_      request    in_valid / in_stall          in_epoch_seconds[31:0]
//   out_     result     out_valid / out_stall        out_year[11:0], out_month[3:0],
//                                                    out_day_of_month[4:0], out_hours[4:0],
//                                                    out_minutes[5:0], out_seconds_out[5:0],
//                                                    out_weekday[2:0]
//
// One request is taken every cycle while in_stall is low. Each request passes through
// eight register stages; the first seven divide by constant reciprocals or multiply
// back and subtract, and the eighth forms the month, day and year into the output registers.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall holds only the stages that are full behind it: empty stages keep filling,
// so bubbles close up and in_stall rises only when every stage holds a request.
module unix_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds_out,
  output logic [2:0]  out_weekday
);
  import ustc_pkg::*;

  // Stage valid bits and per-stage advance enables. A stage loads when it is
  // empty or when the stage after it is loading this cycle.
  logic [STAGES:1] vld_r, vld_nxt;
  logic [STAGES:1] adv;

  always_comb begin
    adv[STAGES] = !vld_r[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld_r[STAGES];

  // Stage 1: whole days. The low seven bits of the seconds count pass through,
  // and the upper bits are divided by 675 with an exact reciprocal.
  logic [50:0] day_prod;
  logic [15:0] s1_days_nxt, s1_days_r;
  logic [24:0] s1_x_r;
  logic [6:0]  s1_lo_r;

  assign day_prod    = in_epoch_seconds[31:DAY_LO_BITS] * 51'(DAY_RCP);
  assign s1_days_nxt = day_prod[DAY_SHIFT+15:DAY_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_days_r <= s1_days_nxt;
      s1_x_r    <= in_epoch_seconds[31:DAY_LO_BITS];
      s1_lo_r   <= in_epoch_seconds[DAY_LO_BITS-1:0];
    end
  end

  // Stage 2: seconds of the day, the shifted day number for the date method,
  // and the day count offset so that its remainder by seven is the weekday.
  // The half-day rounding of the Julian day reduces exactly to days + EPOCH_JDN.
  logic [24:0] day_back, day_rem;
  logic [16:0] s2_tod_nxt, s2_tod_r;
  logic [21:0] s2_n0_nxt, s2_n0_r;
  logic [15:0] s2_wx_nxt, s2_wx_r;

  assign day_back   = s1_days_r * 25'(DAY_DIV);
  assign day_rem    = s1_x_r - day_back;
  assign s2_tod_nxt = {day_rem[9:0], s1_lo_r};
  assign s2_n0_nxt  = 22'(s1_days_r) + 22'(DAY_BASE);
  assign s2_wx_nxt  = s1_days_r + 16'(WEEK_BIAS);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_tod_r <= s2_tod_nxt;
      s2_n0_r  <= s2_n0_nxt;
      s2_wx_r  <= s2_wx_nxt;
    end
  end

  // Stage 3: quotients for 400-year cycles, hours and weeks.
  logic [49:0] cent_prod;
  logic [34:0] hr_prod;
  logic [32:0] wk_prod;
  logic [7:0]  s3_cent_nxt, s3_cent_r;
  logic [4:0]  s3_hr_nxt, s3_hr_r;
  logic [13:0] s3_wq_nxt, s3_wq_r;
  logic [21:0] s3_n0_r;
  logic [16:0] s3_tod_r;
  logic [15:0] s3_wx_r;

  assign cent_prod   = {s2_n0_r, 2'b11} * 50'(CENT_RCP);
  assign s3_cent_nxt = cent_prod[CENT_SHIFT+7:CENT_SHIFT];
  assign hr_prod     = s2_tod_r * 35'(HOUR_RCP);
  assign s3_hr_nxt   = hr_prod[HOUR_SHIFT+4:HOUR_SHIFT];
  assign wk_prod     = s2_wx_r * 33'(WEEK_RCP);
  assign s3_wq_nxt   = wk_prod[WEEK_SHIFT+13:WEEK_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_cent_r <= s3_cent_nxt;
      s3_hr_r   <= s3_hr_nxt;
      s3_wq_r   <= s3_wq_nxt;
      s3_n0_r   <= s2_n0_r;
      s3_tod_r  <= s2_tod_r;
      s3_wx_r   <= s2_wx_r;
    end
  end

  // Stage 4: remove whole 400-year cycles, whole hours and whole weeks.
  logic [25:0] cent_back;
  logic [21:0] n1_full;
  logic [16:0] hr_back, rs_full;
  logic [15:0] wk_back, wd_full;
  logic [15:0] s4_n1_nxt, s4_n1_r;
  logic [11:0] s4_rs_nxt, s4_rs_r;
  logic [2:0]  s4_wday_nxt, s4_wday_r;
  logic [7:0]  s4_cent_r;
  logic [4:0]  s4_hr_r;

  assign cent_back   = s3_cent_r * 26'(DAYS_400Y);
  assign n1_full     = s3_n0_r - cent_back[23:2];
  assign s4_n1_nxt   = n1_full[15:0];
  assign hr_back     = s3_hr_r * 17'(SECS_HOUR);
  assign rs_full     = s3_tod_r - hr_back;
  assign s4_rs_nxt   = rs_full[11:0];
  assign wk_back     = s3_wq_r * 16'(DAYS_WEEK);
  assign wd_full     = s3_wx_r - wk_back;
  assign s4_wday_nxt = wd_full[2:0];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_n1_r   <= s4_n1_nxt;
      s4_rs_r   <= s4_rs_nxt;
      s4_wday_r <= s4_wday_nxt;
      s4_cent_r <= s3_cent_r;
      s4_hr_r   <= s3_hr_r;
    end
  end

  // Stage 5: quotients for 4-year cycles and minutes.
  logic [36:0] quad_prod;
  logic [24:0] min_prod;
  logic [7:0]  s5_quad_nxt, s5_quad_r;
  logic [5:0]  s5_min_nxt, s5_min_r;
  logic [15:0] s5_n1_r;
  logic [11:0] s5_rs_r;
  logic [7:0]  s5_cent_r;
  logic [4:0]  s5_hr_r;
  logic [2:0]  s5_wday_r;

  assign quad_prod   = {s4_n1_r, 2'b11} * 37'(QUAD_RCP);
  assign s5_quad_nxt = quad_prod[QUAD_SHIFT+7:QUAD_SHIFT];
  assign min_prod    = s4_rs_r * 25'(MIN_RCP);
  assign s5_min_nxt  = min_prod[MIN_SHIFT+5:MIN_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_quad_r <= s5_quad_nxt;
      s5_min_r  <= s5_min_nxt;
      s5_n1_r   <= s4_n1_r;
      s5_rs_r   <= s4_rs_r;
      s5_cent_r <= s4_cent_r;
      s5_hr_r   <= s4_hr_r;
      s5_wday_r <= s4_wday_r;
    end
  end

  // Stage 6: day within the March-based year, the year before the January and
  // February correction, and the seconds of the minute.
  logic [17:0] quad_back;
  logic [15:0] n2_full;
  logic [11:0] min_back, sec_full;
  logic [8:0]  s6_n2_nxt, s6_n2_r;
  logic [13:0] s6_ybase_nxt, s6_ybase_r;
  logic [5:0]  s6_sec_nxt, s6_sec_r;
  logic [4:0]  s6_hr_r;
  logic [5:0]  s6_min_r;
  logic [2:0]  s6_wday_r;

  assign quad_back    = s5_quad_r * 18'(DAYS_4Y);
  assign n2_full      = s5_n1_r - quad_back[17:2];
  assign s6_n2_nxt    = n2_full[8:0];
  assign s6_ybase_nxt = s5_cent_r * 14'(CENT_YEARS) + 14'(s5_quad_r) - 14'(YEAR_BIAS);
  assign min_back     = s5_min_r * 12'(SECS_MIN);
  assign sec_full     = s5_rs_r - min_back;
  assign s6_sec_nxt   = sec_full[5:0];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_n2_r    <= s6_n2_nxt;
      s6_ybase_r <= s6_ybase_nxt;
      s6_sec_r   <= s6_sec_nxt;
      s6_hr_r    <= s5_hr_r;
      s6_min_r   <= s5_min_r;
      s6_wday_r  <= s5_wday_r;
    end
  end

  // Stage 7: month of the March-based year, (5n+2)/153.
  logic [10:0] mq_num;
  logic [22:0] mq_prod;
  logic [3:0]  s7_mq_nxt, s7_mq_r;
  logic [8:0]  s7_n2_r;
  logic [13:0] s7_ybase_r;
  logic [4:0]  s7_hr_r;
  logic [5:0]  s7_min_r, s7_sec_r;
  logic [2:0]  s7_wday_r;

  assign mq_num    = s6_n2_r * 11'd5 + 11'd2;
  assign mq_prod   = mq_num * 23'(MQ_RCP);
  assign s7_mq_nxt = mq_prod[MQ_SHIFT+3:MQ_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_mq_r    <= s7_mq_nxt;
      s7_n2_r    <= s6_n2_r;
      s7_ybase_r <= s6_ybase_r;
      s7_hr_r    <= s6_hr_r;
      s7_min_r   <= s6_min_r;
      s7_sec_r   <= s6_sec_r;
      s7_wday_r  <= s6_wday_r;
    end
  end

  // Stage 8: output registers. Month indexes ten and eleven are January and
  // February of the following calendar year.
  logic        mq_late;
  logic [8:0]  mday_full;
  logic [13:0] year_full;
  logic [11:0] out_year_nxt, out_year_r;
  logic [3:0]  out_month_nxt, out_month_r;
  logic [4:0]  out_mday_nxt, out_mday_r;
  logic [4:0]  out_hours_r;
  logic [5:0]  out_minutes_r, out_seconds_r;
  logic [2:0]  out_weekday_r;

  assign mq_late       = s7_mq_r >= 4'(MONTH_WRAP);
  assign out_month_nxt = mq_late ? s7_mq_r - 4'(MONTH_BACK) : s7_mq_r + 4'(MONTH_FWD);
  assign mday_full     = s7_n2_r - month_start(s7_mq_r) + 9'd1;
  assign out_mday_nxt  = mday_full[4:0];
  assign year_full     = s7_ybase_r + 14'(mq_late);
  assign out_year_nxt  = year_full[11:0];

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      out_year_r    <= out_year_nxt;
      out_month_r   <= out_month_nxt;
      out_mday_r    <= out_mday_nxt;
      out_hours_r   <= s7_hr_r;
      out_minutes_r <= s7_min_r;
      out_seconds_r <= s7_sec_r;
      out_weekday_r <= s7_wday_r;
    end
  end

  assign out_year         = out_year_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_mday_r;
  assign out_hours        = out_hours_r;
  assign out_minutes      = out_minutes_r;
  assign out_seconds_out  = out_seconds_r;
  assign out_weekday      = out_weekday_r;

endmodule
